// ===== sv/hai_pkg.sv =====
// Shared types, constants and functions for the half-angle to direction converter.
// Used by hai_cordic and half_angle_to_incident_outgoing; depends on nothing.
package hai_pkg;

    localparam int ANGLE_BITS     = 16;
    localparam int COMPONENT_BITS = 16;
    localparam int CORDIC_STEPS   = 30;
    localparam int CW             = 34;
    localparam int PW             = 70;
    localparam int CORDIC_LAT     = CORDIC_STEPS + 2;
    localparam int PIPE_LAT       = CORDIC_LAT + 3;
    localparam int OUT_SHIFT      = 61 - COMPONENT_BITS;
    localparam logic signed [CW-1:0] CORDIC_GAIN_INV = CW'(652032874);

    typedef logic [ANGLE_BITS-1:0]            t_angle;
    typedef logic signed [COMPONENT_BITS-1:0] t_comp;
    typedef logic signed [CW-1:0]             t_cval;
    typedef logic signed [PW-1:0]             t_wide;

    typedef struct packed {
        t_angle half_angle;
        t_angle diff_elevation;
        t_angle diff_azimuth;
    } t_in_item;

    typedef struct packed {
        t_comp in_dir_x;
        t_comp in_dir_y;
        t_comp in_dir_z;
        t_comp out_dir_x;
        t_comp out_dir_y;
        t_comp out_dir_z;
    } t_out_item;

    function automatic t_cval atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return t_cval'({2'b00, v});
    endfunction

    // round a Q60 value to Q1.(COMPONENT_BITS-1) and saturate
    function automatic t_comp q60_to_out(input t_wide v);
        t_wide r;
        t_wide hi;
        t_wide lo;
        r  = (v + (t_wide'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
        hi = (t_wide'(1) <<< (COMPONENT_BITS - 1)) - t_wide'(1);
        lo = -hi - t_wide'(1);
        if (r > hi) begin
            r = hi;
        end else if (r < lo) begin
            r = lo;
        end
        return r[COMPONENT_BITS-1:0];
    endfunction

endpackage

// ===== sv/half_angle_to_incident_outgoing.sv =====
// Half-angle (theta_h, theta_d, phi_d) to incident/outgoing unit directions.
// Top level; depends on hai_pkg and hai_cordic.
// An item enters every cycle while the pipeline does not hold. It passes through the
// three parallel 30-step sine/cosine pipelines, then one stage each for the
// difference vector products, the rotation products and the rounding sums.
// The whole pipeline holds while a result waits with i_ready low.
module half_angle_to_incident_outgoing (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  hai_pkg::t_in_item    i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output hai_pkg::t_out_item   o_data
);

    localparam int L = hai_pkg::PIPE_LAT;

    logic               n_en;
    logic [L-1:0]       r_vld;
    hai_pkg::t_cval     w_ch, w_sh, w_ct, w_st, w_cp, w_sp;
    logic signed [2*hai_pkg::CW-1:0] n_px, n_py;
    logic signed [2*hai_pkg::CW-1:0] n_xc, n_zs, n_zc, n_xs;
    hai_pkg::t_cval     r_vx, r_vy, r_vz, r_ch, r_sh;
    hai_pkg::t_wide     r_xc, r_zs, r_zc, r_xs, r_y;
    hai_pkg::t_out_item r_out;

    assign n_en    = !o_valid || i_ready;
    assign o_ready = n_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[L-2:0], i_valid};
        end
    end

    hai_cordic u_cordic_h (.i_clk, .i_en(n_en), .i_angle(i_data.half_angle),
        .o_cos(w_ch), .o_sin(w_sh));
    hai_cordic u_cordic_d (.i_clk, .i_en(n_en), .i_angle(i_data.diff_elevation),
        .o_cos(w_ct), .o_sin(w_st));
    hai_cordic u_cordic_p (.i_clk, .i_en(n_en), .i_angle(i_data.diff_azimuth),
        .o_cos(w_cp), .o_sin(w_sp));

    assign n_px = (w_st * w_cp + (2*hai_pkg::CW)'(1 << 29)) >>> 30;
    assign n_py = (w_st * w_sp + (2*hai_pkg::CW)'(1 << 29)) >>> 30;

    assign n_xc = r_vx * r_ch;
    assign n_zs = r_vz * r_sh;
    assign n_zc = r_vz * r_ch;
    assign n_xs = r_vx * r_sh;

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_vx <= n_px[hai_pkg::CW-1:0];
            r_vy <= n_py[hai_pkg::CW-1:0];
            r_vz <= w_ct;
            r_ch <= w_ch;
            r_sh <= w_sh;
            r_xc <= hai_pkg::PW'(n_xc);
            r_zs <= hai_pkg::PW'(n_zs);
            r_zc <= hai_pkg::PW'(n_zc);
            r_xs <= hai_pkg::PW'(n_xs);
            r_y  <= hai_pkg::t_wide'(r_vy) <<< 30;
            r_out.in_dir_x  <= hai_pkg::q60_to_out(r_xc + r_zs);
            r_out.in_dir_y  <= hai_pkg::q60_to_out(r_y);
            r_out.in_dir_z  <= hai_pkg::q60_to_out(r_zc - r_xs);
            r_out.out_dir_x <= hai_pkg::q60_to_out(r_zs - r_xc);
            r_out.out_dir_y <= hai_pkg::q60_to_out(-r_y);
            r_out.out_dir_z <= hai_pkg::q60_to_out(r_zc + r_xs);
        end
    end

    assign o_valid = r_vld[L-1];
    assign o_data  = r_out;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_vld[0])
        else $error("accepted item lost at pipe entry");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

endmodule

// ===== sv/hai_cordic.sv =====
// Pipelined rotation-mode sine/cosine unit, one angle per cycle while i_en is high, Q4.30 results.
// Depends on hai_pkg.
module hai_cordic (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  hai_pkg::t_angle       i_angle,
    output hai_pkg::t_cval        o_cos,
    output hai_pkg::t_cval        o_sin
);

    localparam int N = hai_pkg::CORDIC_STEPS;

    hai_pkg::t_cval r_x [0:N];
    hai_pkg::t_cval r_y [0:N];
    hai_pkg::t_cval r_z [0:N];
    logic           r_f [0:N];
    hai_pkg::t_cval r_cos;
    hai_pkg::t_cval r_sin;

    logic [31:0] n_turn;
    logic        n_flip;

    assign n_turn = {i_angle, (32 - hai_pkg::ANGLE_BITS)'(0)};
    assign n_flip = n_turn[31] ^ n_turn[30];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= hai_pkg::CORDIC_GAIN_INV;
            r_y[0] <= '0;
            r_z[0] <= hai_pkg::t_cval'(signed'({n_turn[31] ^ n_flip, n_turn[30:0]}));
            r_f[0] <= n_flip;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        hai_pkg::t_cval n_dx;
        hai_pkg::t_cval n_dy;
        assign n_dx = r_y[k] >>> k;
        assign n_dy = r_x[k] >>> k;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[k][hai_pkg::CW-1]) begin
                    r_x[k+1] <= r_x[k] - n_dx;
                    r_y[k+1] <= r_y[k] + n_dy;
                    r_z[k+1] <= r_z[k] - hai_pkg::atan_turn(5'(k));
                end else begin
                    r_x[k+1] <= r_x[k] + n_dx;
                    r_y[k+1] <= r_y[k] - n_dy;
                    r_z[k+1] <= r_z[k] + hai_pkg::atan_turn(5'(k));
                end
                r_f[k+1] <= r_f[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= r_f[N] ? -r_x[N] : r_x[N];
            r_sin <= r_f[N] ? -r_y[N] : r_y[N];
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

// ===== tb/tb_direction_checker.sv =====
// Checker for the half-angle to direction converter: watches both channels,
// predicts each result with its own CORDIC and compares. Depends on hai_pkg.
`timescale 1ns / 100ps

module tb_direction_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_in_ready,
    input  hai_pkg::t_in_item   i_in_data,
    input  logic                i_out_valid,
    input  logic                i_ready,
    input  hai_pkg::t_out_item  i_out_data,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_result_count
);

    localparam int N_STEPS = 30;

    hai_pkg::t_out_item expected_dirs[$];

    function automatic longint turn_step(input int k);
        logic [31:0] t [N_STEPS] = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
            32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
            32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};
        return longint'(t[k]);
    endfunction

    function automatic void sin_cos_of(input hai_pkg::t_angle ang,
                                       output longint c, output longint s);
        logic [31:0] a;
        logic        flip;
        longint      x, y, z, dx, dy;
        a = 32'(ang) << (32 - hai_pkg::ANGLE_BITS);
        flip = a[31] ^ a[30];
        if (flip) a = a + 32'h80000000;
        z = longint'(signed'(a));
        x = 652032874;
        y = 0;
        for (int k = 0; k < N_STEPS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x -= dx; y += dy; z -= turn_step(k);
            end else begin
                x += dx; y -= dy; z += turn_step(k);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic hai_pkg::t_comp round_sat(input longint v);
        longint r;
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (hai_pkg::COMPONENT_BITS - 1)) - 1;
        lo = -hi - 1;
        r = (v + (longint'(1) <<< (hai_pkg::OUT_SHIFT - 1))) >>> hai_pkg::OUT_SHIFT;
        if (r > hi) r = hi;
        if (r < lo) r = lo;
        return hai_pkg::t_comp'(r);
    endfunction

    function automatic hai_pkg::t_out_item predict_dirs(input hai_pkg::t_in_item it);
        longint ch, sh, ct, st, cp, sp, vx, vy, vz;
        hai_pkg::t_out_item o;
        sin_cos_of(it.half_angle, ch, sh);
        sin_cos_of(it.diff_elevation, ct, st);
        sin_cos_of(it.diff_azimuth, cp, sp);
        vx = (st * cp + (longint'(1) <<< 29)) >>> 30;
        vy = (st * sp + (longint'(1) <<< 29)) >>> 30;
        vz = ct;
        o.in_dir_x  = round_sat(vx * ch + vz * sh);
        o.in_dir_y  = round_sat(vy <<< 30);
        o.in_dir_z  = round_sat(vz * ch - vx * sh);
        o.out_dir_x = round_sat(-vx * ch + vz * sh);
        o.out_dir_y = round_sat(-(vy <<< 30));
        o.out_dir_z = round_sat(vz * ch + vx * sh);
        return o;
    endfunction

    initial begin
        o_fail_count = 0;
        o_result_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        hai_pkg::t_out_item want;
        if (i_rst_n && i_valid && i_in_ready) begin
            expected_dirs.push_back(predict_dirs(i_in_data));
        end
        if (i_rst_n && i_out_valid && i_ready) begin
            o_result_count <= o_result_count + 1;
            if (expected_dirs.size() == 0) begin
                o_fail_count <= o_fail_count + 1;
                if (o_fail_count < 10) $display("unexpected result %h", i_out_data);
            end else begin
                want = expected_dirs.pop_front();
                if (want !== i_out_data) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("mismatch: expected %h actual %h", want, i_out_data);
                end
            end
        end
        o_pending <= expected_dirs.size();
    end
endmodule

// ===== tb/tb_top.sv =====
// Top of the converter testbench: clock, reset, stimulus, verdict.
// Depends on hai_pkg, half_angle_to_incident_outgoing and tb_direction_checker.
`timescale 1ns / 100ps

module tb_top;

    localparam int WATCHDOG = 20000;
    localparam hai_pkg::t_angle CORNERS [8] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000,
                                                16'hC000, 16'h3FFF, 16'h2000, 16'h0001};

    logic               i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready;
    hai_pkg::t_in_item  i_data;
    hai_pkg::t_out_item o_data;
    int                 fail_count, pending, result_count, quiet_cycles, sent;
    logic               stall_run;

    half_angle_to_incident_outgoing i_dut (.*);

    tb_direction_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_in_ready(o_ready),
        .i_in_data(i_data), .i_out_valid(o_valid), .i_ready(i_ready),
        .i_out_data(o_data), .o_fail_count(fail_count), .o_pending(pending),
        .o_result_count(result_count));

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    task automatic send_item(input hai_pkg::t_in_item it);
        i_data  <= it;
        i_valid <= 1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic pause_input(input int n);
        i_valid <= 0;
        i_data  <= {16'($urandom), 16'($urandom), 16'($urandom)};
        repeat (n) @(negedge i_clk);
    endtask

    initial begin
        hai_pkg::t_in_item it;
        int                gap;
        i_rst_n = 0; i_valid = 0; i_data = '0; sent = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        for (int k = 0; k < 24; k++) begin
            it.half_angle     = CORNERS[k % 8];
            it.diff_elevation = CORNERS[(k / 3) % 8];
            it.diff_azimuth   = CORNERS[(k * 5 + 1) % 8];
            send_item(it);
        end
        for (int k = 0; k < 500; k++) begin
            it.half_angle     = 16'($urandom);
            it.diff_elevation = 16'($urandom);
            it.diff_azimuth   = 16'($urandom);
            send_item(it);
            if (k >= 100 && k < 200) continue;
            if ($urandom_range(0, 1)) begin
                gap = gap_len();
                if (gap > 0) pause_input(gap);
            end
        end
        i_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (hai_pkg::PIPE_LAT + 5) @(posedge i_clk);
        $display("sent %0d items, checked %0d direction pairs", sent, result_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        int n;
        i_ready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall_run = $urandom_range(0, 3) == 0;
            if (stall_run) begin
                n = gap_len();
                if (n > 0) begin
                    i_ready <= 0;
                    repeat (n) @(negedge i_clk);
                end
            end
            i_ready <= 1;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end
endmodule
